[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define SRCH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition in one cycle requires a consequence in the next cycle.
`define SRCH_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[hw/rtl/srch_pkg.sv]
// ----------------------------------------------------------------------------
// srch_pkg
// Shared constants and queue control types of the segment/rectangle clipper.
// ----------------------------------------------------------------------------
`default_nettype none

package srch_pkg;

  // Width of the rectangle size fields
  localparam int unsigned SIZE_BITS = 15;

  // Entries of the queue between the clip front and the entry-point back
  localparam int unsigned MID_DEPTH = 4;

  // Queue requests from the two sides
  typedef struct packed {
    logic push;
    logic pop;
  } srch_qctl_t;

  // Queue status toward the two sides
  typedef struct packed {
    logic full;
    logic empty;
  } srch_qsts_t;

endpackage

`default_nettype wire

[hw/rtl/srch_queue.sv]
// ----------------------------------------------------------------------------
// srch_queue
// Small register FIFO that decouples the clip front from the entry-point back.
// ----------------------------------------------------------------------------
`default_nettype none

module srch_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srch_pkg::srch_qctl_t ctl_i,
  output srch_pkg::srch_qsts_t sts_o,
  input  logic [Width-1:0]    wdata_i,
  output logic [Width-1:0]    rdata_o
);
  import srch_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  // Advance pointers with explicit wrap
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (ctl_i.push) begin
      wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
    end
    if (ctl_i.pop) begin
      rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
    end
    if (ctl_i.push && !ctl_i.pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!ctl_i.push && ctl_i.pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store the incoming transfer
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  assign rdata_o     = mem_q[rd_q];
  assign sts_o.full  = (cnt_q == CW'(Depth));
  assign sts_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

[hw/rtl/srch_front.sv]
// ----------------------------------------------------------------------------
// srch_front
// Accepts segments, forms the edge terms and clips the entry/exit fractions
// against the four rectangle edges, one multiply and one compare stage each.
// ----------------------------------------------------------------------------
`default_nettype none

module srch_front #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic signed [COORD_BITS-1:0]       start_x_i,
  input  logic signed [COORD_BITS-1:0]       start_y_i,
  input  logic signed [COORD_BITS-1:0]       end_x_i,
  input  logic signed [COORD_BITS-1:0]       end_y_i,
  input  logic signed [COORD_BITS-1:0]       rect_left_i,
  input  logic signed [COORD_BITS-1:0]       rect_top_i,
  input  logic [srch_pkg::SIZE_BITS-1:0]     rect_width_i,
  input  logic [srch_pkg::SIZE_BITS-1:0]     rect_height_i,
  output logic                               mid_push_o,
  input  logic                               mid_full_i,
  output logic [6*COORD_BITS+2:0]            mid_data_o
);
  import srch_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned DW = CB + 1;
  localparam int unsigned QW = ((CB > 16) ? CB : 16) + 2;
  localparam int unsigned PW = QW + CB + 1;
  localparam int unsigned NS = 9;

  logic adv;

  logic                 v_q  [NS];
  logic signed [CB-1:0] x0_q [NS];
  logic signed [CB-1:0] y0_q [NS];
  logic signed [DW-1:0] dx_q [NS];
  logic signed [DW-1:0] dy_q [NS];
  logic signed [QW-1:0] q_q  [NS][4];
  logic signed [QW-1:0] n0_q [NS];
  logic signed [QW-1:0] n1_q [NS];
  logic [CB-1:0]        d0_q [NS];
  logic [CB-1:0]        d1_q [NS];
  logic                 ok_q [NS];

  logic signed [QW-1:0] rn_q [4];
  logic [CB-1:0]        rd_q [4];
  logic                 pz_q [4];
  logic                 pn_q [4];
  logic                 qn_q [4];
  logic signed [PW-1:0] pa_q [4];
  logic signed [PW-1:0] pb_q [4];
  logic signed [PW-1:0] pc_q [4];
  logic signed [PW-1:0] pe_q [4];

  logic signed [DW-1:0] dx_d, dy_d;
  logic signed [QW-1:0] q_d [4];
  logic                 hit;

  // Hold the whole pipe while the last stage cannot hand off
  assign full = v_q[NS-1] && mid_full_i;
  assign adv  = !full;

  // Edge distances: left, right, top, bottom
  always_comb begin
    dx_d   = DW'(end_x_i) - DW'(start_x_i);
    dy_d   = DW'(end_y_i) - DW'(start_y_i);
    q_d[0] = QW'(start_x_i) - QW'(rect_left_i);
    q_d[1] = QW'(rect_left_i) + $signed(QW'(rect_width_i)) - QW'(start_x_i);
    q_d[2] = QW'(start_y_i) - QW'(rect_top_i);
    q_d[3] = QW'(rect_top_i) + $signed(QW'(rect_height_i)) - QW'(start_y_i);
  end

  // Valid bits of the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (adv) begin
      v_q[0] <= push;
      for (int k = 1; k < NS; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  // Capture the transfer and start with the interval [0, 1]
  always_ff @(posedge clk_i) begin
    if (adv) begin
      x0_q[0] <= start_x_i;
      y0_q[0] <= start_y_i;
      dx_q[0] <= dx_d;
      dy_q[0] <= dy_d;
      for (int i = 0; i < 4; i++) begin
        q_q[0][i] <= q_d[i];
      end
      n0_q[0] <= '0;
      d0_q[0] <= CB'(1);
      n1_q[0] <= QW'(1);
      d1_q[0] <= CB'(1);
      ok_q[0] <= 1'b1;
    end
  end

  // Carry the segment terms down the pipe
  for (genvar k = 1; k < NS; k++) begin : g_carry
    always_ff @(posedge clk_i) begin
      if (adv) begin
        x0_q[k] <= x0_q[k-1];
        y0_q[k] <= y0_q[k-1];
        dx_q[k] <= dx_q[k-1];
        dy_q[k] <= dy_q[k-1];
        for (int i = 0; i < 4; i++) begin
          q_q[k][i] <= q_q[k-1][i];
        end
      end
    end
  end

  // One multiply stage and one compare stage per edge
  for (genvar e = 0; e < 4; e++) begin : g_edge
    localparam int unsigned SI = 2 * e;
    localparam int unsigned SM = 2 * e + 1;
    localparam int unsigned SC = 2 * e + 2;

    logic signed [DW-1:0] dsel;
    logic signed [QW-1:0] qsel, rn;
    logic [CB-1:0]        rd;
    logic                 dneg, pz, pn;
    logic signed [QW-1:0] n0_c, n1_c;
    logic [CB-1:0]        d0_c, d1_c;
    logic                 ok_c;

    assign dsel = (e < 2) ? dx_q[SI] : dy_q[SI];
    assign dneg = dsel[DW-1];
    assign pz   = (dsel == '0);
    assign pn   = ((e % 2) == 0) ? (!dneg && !pz) : dneg;
    assign rd   = dneg ? CB'(-dsel) : CB'(dsel);
    assign qsel = q_q[SI][e];
    assign rn   = pn ? -qsel : qsel;

    // Cross products of the candidate against both interval ends
    always_ff @(posedge clk_i) begin
      if (adv) begin
        rn_q[e] <= rn;
        rd_q[e] <= rd;
        pz_q[e] <= pz;
        pn_q[e] <= pn;
        qn_q[e] <= qsel[QW-1];
        pa_q[e] <= PW'(rn) * $signed(PW'({1'b0, d0_q[SI]}));
        pb_q[e] <= PW'(n0_q[SI]) * $signed(PW'({1'b0, rd}));
        pc_q[e] <= PW'(rn) * $signed(PW'({1'b0, d1_q[SI]}));
        pe_q[e] <= PW'(n1_q[SI]) * $signed(PW'({1'b0, rd}));
        n0_q[SM] <= n0_q[SI];
        d0_q[SM] <= d0_q[SI];
        n1_q[SM] <= n1_q[SI];
        d1_q[SM] <= d1_q[SI];
        ok_q[SM] <= ok_q[SI];
      end
    end

    // Reject, raise the entry or lower the exit
    always_comb begin
      n0_c = n0_q[SM];
      d0_c = d0_q[SM];
      n1_c = n1_q[SM];
      d1_c = d1_q[SM];
      ok_c = ok_q[SM];
      if (pz_q[e]) begin
        if (qn_q[e]) begin
          ok_c = 1'b0;
        end
      end else if (pn_q[e]) begin
        if (pc_q[e] > pe_q[e]) begin
          ok_c = 1'b0;
        end else if (pa_q[e] > pb_q[e]) begin
          n0_c = rn_q[e];
          d0_c = rd_q[e];
        end
      end else begin
        if (pa_q[e] < pb_q[e]) begin
          ok_c = 1'b0;
        end else if (pc_q[e] < pe_q[e]) begin
          n1_c = rn_q[e];
          d1_c = rd_q[e];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        n0_q[SC] <= n0_c;
        d0_q[SC] <= d0_c;
        n1_q[SC] <= n1_c;
        d1_q[SC] <= d1_c;
        ok_q[SC] <= ok_c;
      end
    end
  end

  // Entry must not lie past the segment end
  assign hit = ok_q[NS-1] && (n0_q[NS-1] <= $signed(QW'({1'b0, d0_q[NS-1]})));

  assign mid_push_o = v_q[NS-1] && !mid_full_i;
  assign mid_data_o = {hit, x0_q[NS-1], y0_q[NS-1], dx_q[NS-1], dy_q[NS-1],
                       n0_q[NS-1][CB-1:0], d0_q[NS-1]};

endmodule

`default_nettype wire

[hw/rtl/srch_back.sv]
// ----------------------------------------------------------------------------
// srch_back
// Computes the entry point start + n/d * delta for both axes with a
// one-bit-per-stage pipelined divider and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module srch_back #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         mid_empty_i,
  output logic                         mid_pop_o,
  input  logic [6*COORD_BITS+2:0]      mid_data_i,
  output logic                         empty,
  input  logic                         pop,
  output logic                         hit_o,
  output logic signed [COORD_BITS-1:0] hit_x_o,
  output logic signed [COORD_BITS-1:0] hit_y_o
);
  import srch_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned DW = CB + 1;
  localparam int unsigned VW = 2 * CB;
  localparam int unsigned BW = CB + 2;
  localparam int unsigned NS = CB + 1;

  // One restoring division step on the joined remainder/quotient word
  function automatic logic [VW-1:0] div_step(input logic [VW-1:0] dv,
                                             input logic [CB-1:0] d);
    logic [CB:0] top;
    logic [CB:0] dif;
    top = dv[VW-1:CB-1];
    dif = top - {1'b0, d};
    if (top >= {1'b0, d}) begin
      div_step = {dif[CB-1:0], dv[CB-2:0], 1'b1};
    end else begin
      div_step = {top[CB-1:0], dv[CB-2:0], 1'b0};
    end
  endfunction

  logic                 m_hit;
  logic signed [CB-1:0] m_x0, m_y0;
  logic signed [DW-1:0] m_dx, m_dy;
  logic [CB-1:0]        m_n0, m_d0, mag_x, mag_y;

  logic                 adv;
  logic                 v_q   [NS];
  logic                 hit_q [NS];
  logic signed [CB-1:0] x0_q  [NS];
  logic signed [CB-1:0] y0_q  [NS];
  logic                 nx_q  [NS];
  logic                 ny_q  [NS];
  logic [CB-1:0]        d_q   [NS];
  logic [VW-1:0]        dvx_q [NS];
  logic [VW-1:0]        dvy_q [NS];

  logic                 out_v_q;
  logic                 out_hit_q;
  logic signed [CB-1:0] out_x_q, out_y_q;
  logic signed [BW-1:0] bx, by;

  assign {m_hit, m_x0, m_y0, m_dx, m_dy, m_n0, m_d0} = mid_data_i;
  assign mag_x = m_dx[DW-1] ? CB'(-m_dx) : CB'(m_dx);
  assign mag_y = m_dy[DW-1] ? CB'(-m_dy) : CB'(m_dy);

  // Hold everything while a finished result waits
  assign adv       = !(out_v_q && !pop);
  assign mid_pop_o = adv && !mid_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) begin
        v_q[k] <= 1'b0;
      end
      out_v_q <= 1'b0;
    end else if (adv) begin
      v_q[0] <= mid_pop_o;
      for (int k = 1; k < NS; k++) begin
        v_q[k] <= v_q[k-1];
      end
      out_v_q <= v_q[NS-1];
    end
  end

  // Form n * |delta| for both axes
  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q[0] <= m_hit;
      x0_q[0]  <= m_x0;
      y0_q[0]  <= m_y0;
      nx_q[0]  <= m_dx[DW-1];
      ny_q[0]  <= m_dy[DW-1];
      d_q[0]   <= m_d0;
      dvx_q[0] <= VW'(m_n0) * VW'(mag_x);
      dvy_q[0] <= VW'(m_n0) * VW'(mag_y);
    end
  end

  // Divide by d, one quotient bit per stage
  for (genvar k = 1; k < NS; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (adv) begin
        hit_q[k] <= hit_q[k-1];
        x0_q[k]  <= x0_q[k-1];
        y0_q[k]  <= y0_q[k-1];
        nx_q[k]  <= nx_q[k-1];
        ny_q[k]  <= ny_q[k-1];
        d_q[k]   <= d_q[k-1];
        dvx_q[k] <= div_step(dvx_q[k-1], d_q[k-1]);
        dvy_q[k] <= div_step(dvy_q[k-1], d_q[k-1]);
      end
    end
  end

  // Add the quotient to the start point and truncate toward zero
  always_comb begin
    if (nx_q[NS-1]) begin
      bx = BW'(x0_q[NS-1]) - $signed(BW'(dvx_q[NS-1][CB-1:0]));
      if ((dvx_q[NS-1][VW-1:CB] != '0) && (bx > 0)) begin
        bx = bx - BW'(1);
      end
    end else begin
      bx = BW'(x0_q[NS-1]) + $signed(BW'(dvx_q[NS-1][CB-1:0]));
      if ((dvx_q[NS-1][VW-1:CB] != '0) && (bx < 0)) begin
        bx = bx + BW'(1);
      end
    end
    if (ny_q[NS-1]) begin
      by = BW'(y0_q[NS-1]) - $signed(BW'(dvy_q[NS-1][CB-1:0]));
      if ((dvy_q[NS-1][VW-1:CB] != '0) && (by > 0)) begin
        by = by - BW'(1);
      end
    end else begin
      by = BW'(y0_q[NS-1]) + $signed(BW'(dvy_q[NS-1][CB-1:0]));
      if ((dvy_q[NS-1][VW-1:CB] != '0) && (by < 0)) begin
        by = by + BW'(1);
      end
    end
  end

  // Result register; zero the point on a miss
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_hit_q <= hit_q[NS-1];
      out_x_q   <= hit_q[NS-1] ? bx[CB-1:0] : '0;
      out_y_q   <= hit_q[NS-1] ? by[CB-1:0] : '0;
    end
  end

  assign empty   = !out_v_q;
  assign hit_o   = out_hit_q;
  assign hit_x_o = out_x_q;
  assign hit_y_o = out_y_q;

endmodule

`default_nettype wire

[hw/rtl/segment_rect_clip_hit.sv]
// ----------------------------------------------------------------------------
// segment_rect_clip_hit
// Liang-Barsky clip of a segment against an axis-aligned rectangle, giving a
// hit flag and the truncated point of entry.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: a segment and rectangle transfer when
//   push is high and full is low. Result side is a queue read port: the
//   oldest result sits on hit_o/hit_x_o/hit_y_o while empty is low and
//   transfers when pop is high.
//   Throughput is one segment per cycle while nothing stalls. A result passes
//   COORD_BITS + 12 registers, the first loaded at the edge that transfers
//   its input: 9 clip stages (a capture stage, then one multiply and one
//   compare stage per edge), the queue, one multiply stage, COORD_BITS
//   divider stages (one quotient bit each) and the result register.
//   A result that is not popped holds the divider pipe; the four-entry queue
//   then fills and the clip pipe holds, which shows as full.
//   Reset empties every stage and the queue; empty is high after reset.
//   A miss gives hit_o low and a zero point.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_rect_clip_hit #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic signed [COORD_BITS-1:0]   start_x_i,
  input  logic signed [COORD_BITS-1:0]   start_y_i,
  input  logic signed [COORD_BITS-1:0]   end_x_i,
  input  logic signed [COORD_BITS-1:0]   end_y_i,
  input  logic signed [COORD_BITS-1:0]   rect_left_i,
  input  logic signed [COORD_BITS-1:0]   rect_top_i,
  input  logic [srch_pkg::SIZE_BITS-1:0] rect_width_i,
  input  logic [srch_pkg::SIZE_BITS-1:0] rect_height_i,
  output logic                           empty,
  input  logic                           pop,
  output logic                           hit_o,
  output logic signed [COORD_BITS-1:0]   hit_x_o,
  output logic signed [COORD_BITS-1:0]   hit_y_o
);
  import srch_pkg::*;

  localparam int unsigned MW = 6 * COORD_BITS + 3;

  srch_qctl_t     q_ctl;
  srch_qsts_t     q_sts;
  logic [MW-1:0]  q_wdata, q_rdata;
  logic           f_push, b_pop;

  srch_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .rect_left_i   (rect_left_i),
    .rect_top_i    (rect_top_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .mid_push_o    (f_push),
    .mid_full_i    (q_sts.full),
    .mid_data_o    (q_wdata)
  );

  assign q_ctl.push = f_push;
  assign q_ctl.pop  = b_pop;

  srch_queue #(.Width(MW), .Depth(MID_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (q_ctl),
    .sts_o   (q_sts),
    .wdata_i (q_wdata),
    .rdata_o (q_rdata)
  );

  srch_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (q_sts.empty),
    .mid_pop_o   (b_pop),
    .mid_data_i  (q_rdata),
    .empty       (empty),
    .pop         (pop),
    .hit_o       (hit_o),
    .hit_x_o     (hit_x_o),
    .hit_y_o     (hit_y_o)
  );

endmodule

`default_nettype wire

[hw/rtl/srch_checker.sv]
// ----------------------------------------------------------------------------
// srch_checker
// Port-level checks of the segment/rectangle clipper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module srch_checker #(
  parameter int unsigned COORD_BITS = 16
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           push,
  input logic                           full,
  input logic                           empty,
  input logic                           pop,
  input logic                           hit_o,
  input logic signed [COORD_BITS-1:0]   hit_x_o,
  input logic signed [COORD_BITS-1:0]   hit_y_o
);

  logic [7:0] pend_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = push && !full;
  assign out_xfer = pop && !empty;

  // Count segments taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      pend_q <= pend_q + 8'd1;
    end else if (!in_xfer && out_xfer) begin
      pend_q <= pend_q - 8'd1;
    end
  end

  `SRCH_ASSERT(a_miss_zero, clk_i, rst_ni, (!empty && !hit_o) |-> (hit_x_o == '0 && hit_y_o == '0), "miss result carries a nonzero point")
  `SRCH_ASSERT_NEXT(a_result_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(hit_o) && $stable(hit_x_o) && $stable(hit_y_o), "stalled result changed")
  `SRCH_ASSERT(a_no_phantom, clk_i, rst_ni, (pend_q == '0) |-> empty, "result shown with nothing outstanding")
  `SRCH_ASSERT(a_full_busy, clk_i, rst_ni, full |-> (pend_q != '0), "full with nothing outstanding")

endmodule

bind segment_rect_clip_hit srch_checker #(.COORD_BITS(COORD_BITS)) u_srch_checker (.*);

`default_nettype wire
